FILE: rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, codes and the CRC-8 byte step for the CRC-8 frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  // CRC-8 generator polynomial, MSB first, without the implicit x^8 term.
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Parser phase codes.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_OPCODE = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC    = 3'd4
  } phase_t;

  // One received byte with its frame marker.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  // One parsed frame.
  typedef struct packed {
    logic [7:0]  device_addr;
    logic [7:0]  op_code;
    logic [7:0]  data_length;
    logic [15:0] value;
    logic        crc_ok;
    logic [7:0]  computed_crc;
    logic [7:0]  received_crc;
  } out_item_t;

  // One byte through the CRC-8 register, eight bit steps unrolled.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/cfd_in_if.sv
// ----------------------------------------------------------------------------
// cfd_in_if
// Valid/ready channel that carries received frame bytes.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic              valid;
  logic              ready;
  cfd_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/cfd_out_if.sv
// ----------------------------------------------------------------------------
// cfd_out_if
// Valid/ready channel that carries parsed frame results.
// ----------------------------------------------------------------------------
interface cfd_out_if;
  logic               valid;
  logic               ready;
  cfd_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/crc8_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc8_frame_deframer
// Streaming parser for CRC-8 checked reply frames, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while not stalled and emits one
// result per frame after its trailing CRC byte is taken. A frame is an address,
// an opcode, a length byte, that many data bytes and a CRC-8 byte (polynomial
// 0x07, initial value 0, MSB first); frame_start must mark the address byte.
// Bytes outside a frame are dropped, and a new frame_start abandons a partial
// frame without a result. The CRC step and the byte counter are evaluated in
// the cycle the byte is taken, so the rate is one byte per cycle. Results sit
// in an output register backed by one skid entry; the byte input stalls only
// while both hold results that the sink has not taken.
module crc8_frame_deframer (
  input  logic         clk,
  input  logic         rst,
  cfd_in_if.sink       ingress,
  cfd_out_if.source    egress
);

  // Parser state.
  cfd_pkg::phase_t phase;
  cfd_pkg::phase_t phase_next;
  logic [7:0]      data_remaining;
  logic [7:0]      running_crc;
  logic [7:0]      addr_hold;
  logic [7:0]      opcode_hold;
  logic [7:0]      length_hold;
  logic [7:0]      prev_byte;
  logic [7:0]      last_byte;

  // Result buffering.
  logic               out_valid;
  cfd_pkg::out_item_t out_data;
  logic               skid_valid;
  cfd_pkg::out_item_t skid_data;

  logic               in_fire;
  logic               out_pop;
  logic               produce;
  logic [7:0]         rx;
  logic               start;
  logic [7:0]         crc_step;
  logic [7:0]         remaining_dec;
  cfd_pkg::out_item_t result;

  assign rx            = ingress.payload.rx_byte;
  assign start         = ingress.payload.frame_start;
  assign in_fire       = ingress.valid && ingress.ready;
  assign out_pop       = out_valid && egress.ready;
  assign crc_step      = cfd_pkg::crc8_update(start ? 8'h00 : running_crc, rx);
  assign remaining_dec = data_remaining - 8'd1;

  assign ingress.ready  = !skid_valid;
  assign egress.valid   = out_valid;
  assign egress.payload = out_data;

  // Next phase and result detection for the byte on the input.
  always_comb begin
    phase_next = phase;
    produce    = 1'b0;
    if (start) begin
      phase_next = cfd_pkg::PH_OPCODE;
    end else begin
      case (phase)
        cfd_pkg::PH_IDLE:   phase_next = cfd_pkg::PH_IDLE;
        cfd_pkg::PH_OPCODE: phase_next = cfd_pkg::PH_LENGTH;
        cfd_pkg::PH_LENGTH: phase_next = (rx == 8'h00) ? cfd_pkg::PH_CRC : cfd_pkg::PH_DATA;
        cfd_pkg::PH_DATA:   phase_next = (remaining_dec == 8'h00) ? cfd_pkg::PH_CRC
                                                                   : cfd_pkg::PH_DATA;
        cfd_pkg::PH_CRC: begin
          phase_next = cfd_pkg::PH_IDLE;
          produce    = in_fire;
        end
        default:            phase_next = cfd_pkg::PH_IDLE;
      endcase
    end
  end

  // The result that the CRC byte completes.
  always_comb begin
    result.device_addr  = addr_hold;
    result.op_code      = opcode_hold;
    result.data_length  = length_hold;
    result.value        = {prev_byte, last_byte};
    result.crc_ok       = (running_crc == rx);
    result.computed_crc = running_crc;
    result.received_crc = rx;
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cfd_pkg::PH_IDLE;
    end else if (in_fire) begin
      phase <= phase_next;
    end
  end

  // Header, data and CRC registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_remaining <= 8'h00;
      running_crc    <= 8'h00;
      addr_hold      <= 8'h00;
      opcode_hold    <= 8'h00;
      length_hold    <= 8'h00;
      prev_byte      <= 8'h00;
      last_byte      <= 8'h00;
    end else if (in_fire) begin
      if (start) begin
        addr_hold      <= rx;
        opcode_hold    <= 8'h00;
        length_hold    <= 8'h00;
        prev_byte      <= 8'h00;
        last_byte      <= 8'h00;
        data_remaining <= 8'h00;
        running_crc    <= crc_step;
      end else begin
        case (phase)
          cfd_pkg::PH_OPCODE: begin
            opcode_hold <= rx;
            running_crc <= crc_step;
          end
          cfd_pkg::PH_LENGTH: begin
            length_hold    <= rx;
            data_remaining <= rx;
            running_crc    <= crc_step;
          end
          cfd_pkg::PH_DATA: begin
            prev_byte      <= last_byte;
            last_byte      <= rx;
            running_crc    <= crc_step;
            data_remaining <= remaining_dec;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= produce;
      end else begin
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves; no reset needed.
  always_ff @(posedge clk) begin
    if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (produce) begin
      skid_data <= result;
    end
  end

  // The skid entry only fills behind a held result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  // A full skid entry must stop byte transfers.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> !ingress.ready)
    else $error("byte input open while the skid entry is full");

  // A marked byte always opens a new frame.
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && start) |=> (phase == cfd_pkg::PH_OPCODE))
    else $error("frame start did not move the parser to the opcode phase");

  // The data phase never runs with no bytes left to count.
  assert property (@(posedge clk) disable iff (rst)
    (phase == cfd_pkg::PH_DATA) |-> (data_remaining != 8'h00))
    else $error("data phase with zero bytes remaining");

  // A result appears only after a CRC byte was taken or a skid entry moved up.
  assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !skid_valid && !produce) |=> !out_valid)
    else $error("result appeared without a CRC byte");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-8 frame deframer.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes runs first. It covers a stray byte after
// reset, an all-zero frame, an all-ones frame, a correct CRC and a frame cut
// short by a new frame start. Random frames follow. Most of them are well
// formed, with random contents and lengths, and either a correct or a random
// CRC byte. Some are cut short; some follow stray bytes. A local parser
// model tracks every accepted byte, and each result from the block is
// compared field by field with the oldest prediction. Both channels idle in
// random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_TARGET = 1000;
  localparam int TAIL_START  = 850;
  localparam int CYCLE_LIMIT = 200000;

  // One row of the directed table.
  typedef struct {
    logic [7:0]         rx;
    logic               start;
    bit                 fill_crc;
    bit                 typed;
    cfd_pkg::out_item_t want;
  } byte_row_t;

  logic clk;
  logic rst;

  cfd_in_if  byte_ch ();
  cfd_out_if frame_ch ();

  crc8_frame_deframer uut (
    .clk     (clk),
    .rst     (rst),
    .ingress (byte_ch),
    .egress  (frame_ch)
  );

  // Parser model state.
  cfd_pkg::phase_t mdl_phase;
  logic [7:0]      mdl_left;
  logic [7:0]      mdl_crc;
  logic [7:0]      mdl_addr;
  logic [7:0]      mdl_op;
  logic [7:0]      mdl_len;
  logic [7:0]      mdl_prev;
  logic [7:0]      mdl_last;

  cfd_pkg::out_item_t frames_due[$];
  int                 fault_count = 0;
  int                 cycle_count = 0;
  int                 bytes_sent = 0;
  bit                 gappy = 0;
  bit                 tail_run = 0;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // CRC-8 over one byte, one bit at a time from the MSB.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? cfd_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  // Advances the parser model by one byte and returns 1 when a frame closes.
  function automatic bit parse_byte(input logic [7:0] b, input logic s,
                                    output cfd_pkg::out_item_t res);
    res = '0;
    if (s) begin
      mdl_addr = b;
      mdl_op = 8'h00;
      mdl_len = 8'h00;
      mdl_prev = 8'h00;
      mdl_last = 8'h00;
      mdl_left = 8'h00;
      mdl_crc = crc8_step(8'h00, b);
      mdl_phase = cfd_pkg::PH_OPCODE;
      return 1'b0;
    end
    case (mdl_phase)
      cfd_pkg::PH_OPCODE: begin
        mdl_op = b;
        mdl_crc = crc8_step(mdl_crc, b);
        mdl_phase = cfd_pkg::PH_LENGTH;
      end
      cfd_pkg::PH_LENGTH: begin
        mdl_len = b;
        mdl_left = b;
        mdl_crc = crc8_step(mdl_crc, b);
        mdl_phase = (b == 8'h00) ? cfd_pkg::PH_CRC : cfd_pkg::PH_DATA;
      end
      cfd_pkg::PH_DATA: begin
        mdl_prev = mdl_last;
        mdl_last = b;
        mdl_crc = crc8_step(mdl_crc, b);
        mdl_left = mdl_left - 8'd1;
        if (mdl_left == 8'h00) begin
          mdl_phase = cfd_pkg::PH_CRC;
        end
      end
      cfd_pkg::PH_CRC: begin
        res.device_addr = mdl_addr;
        res.op_code = mdl_op;
        res.data_length = mdl_len;
        res.value = {mdl_prev, mdl_last};
        res.crc_ok = (mdl_crc == b);
        res.computed_crc = mdl_crc;
        res.received_crc = b;
        mdl_phase = cfd_pkg::PH_IDLE;
        return 1'b1;
      end
      default: begin
        mdl_phase = cfd_pkg::PH_IDLE;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic byte_row_t row(input logic [7:0] rx, input logic start,
                                    input bit fill_crc = 1'b0, input bit typed = 1'b0,
                                    input cfd_pkg::out_item_t want = '0);
    byte_row_t r;
    r.rx = rx;
    r.start = start;
    r.fill_crc = fill_crc;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fault_count++;
    if (fault_count <= 50) begin
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  // Offers one byte, waits for its transfer and records the predicted result.
  task automatic send_byte(input logic [7:0] b, input logic s, input bit typed = 1'b0,
                           input cfd_pkg::out_item_t want = '0);
    cfd_pkg::out_item_t pred;
    bit                 closes;
    if (gappy && !tail_run && $urandom_range(0, 7) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.payload <= {b, s};
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    closes = parse_byte(b, s, pred);
    if (closes) begin
      frames_due.push_back(typed ? want : pred);
    end
  endtask

  // Sink side: ready drops in random bursts until the closing stretch.
  initial begin
    frame_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!tail_run && $urandom_range(0, 4) == 0) begin
        frame_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Result checker: each transfer is matched with the oldest prediction.
  always @(posedge clk) begin : check_frames
    cfd_pkg::out_item_t got;
    cfd_pkg::out_item_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      got = frame_ch.payload;
      if (frames_due.size() == 0) begin
        report("result with none expected, device_addr", 32'(got.device_addr), 32'd0);
      end else begin
        want = frames_due.pop_front();
        if (got.device_addr !== want.device_addr)
          report("device_addr", 32'(got.device_addr), 32'(want.device_addr));
        if (got.op_code !== want.op_code)
          report("op_code", 32'(got.op_code), 32'(want.op_code));
        if (got.data_length !== want.data_length)
          report("data_length", 32'(got.data_length), 32'(want.data_length));
        if (got.value !== want.value)
          report("value", 32'(got.value), 32'(want.value));
        if (got.crc_ok !== want.crc_ok)
          report("crc_ok", 32'(got.crc_ok), 32'(want.crc_ok));
        if (got.computed_crc !== want.computed_crc)
          report("computed_crc", 32'(got.computed_crc), 32'(want.computed_crc));
        if (got.received_crc !== want.received_crc)
          report("received_crc", 32'(got.received_crc), 32'(want.received_crc));
      end
    end
  end

  // Stimulus: reset, the directed table, then random frames.
  initial begin
    byte_row_t  plan[$];
    byte_row_t  r;
    int         len;
    int         total;
    int         cut;
    bit         good_crc;
    logic [7:0] b;
    logic [7:0] run_crc;

    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.payload <= '0;
    mdl_phase = cfd_pkg::PH_IDLE;
    mdl_left = 8'h00;
    mdl_crc = 8'h00;
    mdl_addr = 8'h00;
    mdl_op = 8'h00;
    mdl_len = 8'h00;
    mdl_prev = 8'h00;
    mdl_last = 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A stray byte right after reset is dropped.
    plan.push_back(row(8'h5A, 1'b0));
    // All-zero frame of zero length: the CRC of zeros is zero, so it matches.
    plan.push_back(row(8'h00, 1'b1));
    plan.push_back(row(8'h00, 1'b0));
    plan.push_back(row(8'h00, 1'b0));
    plan.push_back(row(8'h00, 1'b0, 1'b0, 1'b1,
                       '{8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 8'h00, 8'h00}));
    // All-ones frame with one data byte and a wrong CRC.
    plan.push_back(row(8'hFF, 1'b1));
    plan.push_back(row(8'hFF, 1'b0));
    plan.push_back(row(8'h01, 1'b0));
    plan.push_back(row(8'hFF, 1'b0));
    plan.push_back(row(8'hFF, 1'b0));
    // Two data bytes with a correct CRC.
    plan.push_back(row(8'hA5, 1'b1));
    plan.push_back(row(8'h3C, 1'b0));
    plan.push_back(row(8'h02, 1'b0));
    plan.push_back(row(8'h12, 1'b0));
    plan.push_back(row(8'h34, 1'b0));
    plan.push_back(row(8'h00, 1'b0, 1'b1));
    // A new frame start in the middle of the data abandons the partial frame.
    plan.push_back(row(8'h11, 1'b1));
    plan.push_back(row(8'h22, 1'b0));
    plan.push_back(row(8'h05, 1'b0));
    plan.push_back(row(8'hAA, 1'b0));
    plan.push_back(row(8'h33, 1'b1));
    plan.push_back(row(8'h44, 1'b0));
    plan.push_back(row(8'h00, 1'b0));
    plan.push_back(row(8'h00, 1'b0, 1'b1));
    // A byte after a finished frame without a frame start is dropped.
    plan.push_back(row(8'h77, 1'b0));

    foreach (plan[i]) begin
      r = plan[i];
      gappy = $urandom_range(0, 1);
      send_byte(r.fill_crc ? mdl_crc : r.rx, r.start, r.typed, r.want);
    end

    // Random frames, mostly well formed and short.
    while (bytes_sent < BYTE_TARGET) begin
      tail_run = (bytes_sent > TAIL_START);
      gappy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      case ($urandom_range(0, 99)) inside
        [0:39]:  len = $urandom_range(0, 2);
        [40:89]: len = $urandom_range(3, 8);
        [90:97]: len = $urandom_range(9, 40);
        default: len = $urandom_range(41, 255);
      endcase
      total = len + 4;
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total - 1) : total;
      good_crc = ($urandom_range(0, 9) < 7);
      run_crc = 8'h00;
      for (int i = 0; i < cut; i++) begin
        if (i == total - 1) begin
          b = good_crc ? run_crc : 8'($urandom_range(0, 255));
        end else if (i == 2) begin
          b = 8'(len);
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        run_crc = crc8_step(run_crc, b);
        send_byte(b, i == 0);
        bytes_sent++;
      end
    end
    byte_ch.valid <= 1'b0;

    // Drain, then keep watching for any unexpected result before the verdict.
    while (frames_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fault_count == 0 && frames_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
